// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the pan/tilt servo tracker
// Field widths, register indexes, reset values and the shared multiplier
// request format.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int POS_W   = 11;   // signed detected position
  localparam int ERR_W   = 12;   // signed position error
  localparam int ANG_W   = 8;    // servo angle
  localparam int CMP_W   = 15;   // PWM compare value
  localparam int TGT_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int MB_W    = 27;   // unsigned multiplier operand
  localparam int PROD_W  = ERR_W + MB_W + 1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH = 3'd6;

  localparam logic [TGT_W-1:0]  RST_TARGET_X  = 10'd160;
  localparam logic [TGT_W-1:0]  RST_TARGET_Y  = 10'd120;
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd3277;
  localparam logic [ANG_W-1:0]  RST_PAN_LOW   = 8'd40;
  localparam logic [ANG_W-1:0]  RST_PAN_HIGH  = 8'd200;
  localparam logic [ANG_W-1:0]  RST_TILT_LOW  = 8'd120;
  localparam logic [ANG_W-1:0]  RST_TILT_HIGH = 8'd200;

  localparam logic [ANG_W-1:0]  RST_PAN  = 8'd120;
  localparam logic [ANG_W-1:0]  RST_TILT = 8'd140;

  // ceil(74.074 * 2^20): exact floor(angle * 74074 / 1000) for all 8-bit angles
  localparam logic [MB_W-1:0]   CMP_MULT   = 27'd77672219;
  localparam int                CMP_SHIFT  = 20;
  localparam logic [CMP_W-1:0]  CMP_OFFSET = 15'd8750;

  localparam logic signed [POS_W-1:0] NO_POINT = -11'sd1;

  typedef struct packed {
    logic [TGT_W-1:0]  target_x;
    logic [TGT_W-1:0]  target_y;
    logic [GAIN_W-1:0] gain;
    logic [ANG_W-1:0]  pan_low;
    logic [ANG_W-1:0]  pan_high;
    logic [ANG_W-1:0]  tilt_low;
    logic [ANG_W-1:0]  tilt_high;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] a;
    logic [MB_W-1:0]         b;
  } mul_req_t;

endpackage

// ===== rtl/core/pts_in_if.sv =====
// ----------------------------------------------------------------------------
// pts_in_if: detected position channel
// Valid/ready channel carrying one detected object position per item.
// ----------------------------------------------------------------------------
interface pts_in_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] point_x;
  logic signed [10:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/core/pts_out_if.sv =====
// ----------------------------------------------------------------------------
// pts_out_if: servo result channel
// Valid/ready channel carrying the angles and PWM compare values per item.
// ----------------------------------------------------------------------------
interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pan_angle;
  logic [7:0]  tilt_angle;
  logic [14:0] pan_compare;
  logic [14:0] tilt_compare;
  logic        tracked;

  modport source (output valid, output pan_angle, output tilt_angle,
                  output pan_compare, output tilt_compare, output tracked,
                  input ready);
  modport sink   (input valid, input pan_angle, input tilt_angle,
                  input pan_compare, input tilt_compare, input tracked,
                  output ready);
endinterface

// ===== rtl/core/pts_cfg.sv =====
// ----------------------------------------------------------------------------
// pts_cfg: configuration register file
// Holds the targets, gain and angle windows; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pts_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pts_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output pts_pkg::cfg_t                 cfg
);
  import pts_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:  cfg_nxt.target_x  = cfg_wdata[TGT_W-1:0];
        REG_TARGET_Y:  cfg_nxt.target_y  = cfg_wdata[TGT_W-1:0];
        REG_GAIN:      cfg_nxt.gain      = cfg_wdata[GAIN_W-1:0];
        REG_PAN_LOW:   cfg_nxt.pan_low   = cfg_wdata[ANG_W-1:0];
        REG_PAN_HIGH:  cfg_nxt.pan_high  = cfg_wdata[ANG_W-1:0];
        REG_TILT_LOW:  cfg_nxt.tilt_low  = cfg_wdata[ANG_W-1:0];
        REG_TILT_HIGH: cfg_nxt.tilt_high = cfg_wdata[ANG_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x  <= RST_TARGET_X;
      cfg_r.target_y  <= RST_TARGET_Y;
      cfg_r.gain      <= RST_GAIN;
      cfg_r.pan_low   <= RST_PAN_LOW;
      cfg_r.pan_high  <= RST_PAN_HIGH;
      cfg_r.tilt_low  <= RST_TILT_LOW;
      cfg_r.tilt_high <= RST_TILT_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pts_mul.sv =====
// ----------------------------------------------------------------------------
// pts_mul: shared multiplier
// Signed 12-bit by unsigned 27-bit multiply with a registered product.
// ----------------------------------------------------------------------------
module pts_mul (
  input  logic                                   clk,
  input  pts_pkg::mul_req_t                      req,
  output logic signed [pts_pkg::PROD_W-1:0]      prod
);
  import pts_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;

  always_comb begin
    // Both operands are widened to the full product width before the multiply.
    a_ext    = PROD_W'(req.a);
    b_ext    = $signed(PROD_W'(req.b));
    prod_nxt = a_ext * b_ext;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl: tracking sequencer
// Steps one item through the shared multiplier, updates the angles and
// loads the output register.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pts_pkg::cfg_t                     cfg,
  pts_in_if.sink                            in_ch,
  pts_out_if.source                         out_ch,
  output pts_pkg::mul_req_t                 mul_req,
  input  logic signed [pts_pkg::PROD_W-1:0] prod
);
  import pts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EX   = 3'd1;  // multiply pan error by gain
  localparam logic [2:0] S_EY   = 3'd2;  // multiply tilt error, move pan
  localparam logic [2:0] S_CP   = 3'd3;  // move tilt, pan compare multiply
  localparam logic [2:0] S_CT   = 3'd4;  // tilt compare multiply
  localparam logic [2:0] S_DONE = 3'd5;  // load the output register

  localparam int CAND_W = ERR_W + 1;

  logic [2:0]              state_r, state_nxt;
  logic [ANG_W-1:0]        pan_r, pan_nxt;
  logic [ANG_W-1:0]        tilt_r, tilt_nxt;
  logic signed [ERR_W-1:0] errx_r, errx_nxt;
  logic signed [ERR_W-1:0] erry_r, erry_nxt;
  logic                    trk_r, trk_nxt;
  logic [CMP_W-1:0]        pcmp_r, pcmp_nxt;

  logic                    ov_r, ov_nxt;
  logic [ANG_W-1:0]        opan_r, opan_nxt;
  logic [ANG_W-1:0]        otilt_r, otilt_nxt;
  logic [CMP_W-1:0]        opcmp_r, opcmp_nxt;
  logic [CMP_W-1:0]        otcmp_r, otcmp_nxt;
  logic                    otrk_r, otrk_nxt;

  logic                    accept;
  logic                    out_free;
  logic signed [ERR_W-1:0] delta;
  logic signed [CAND_W-1:0] cand_pan;
  logic signed [CAND_W-1:0] cand_tilt;
  logic [CMP_W-1:0]        cmp_val;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;

  // Round to nearest, ties upward: add one half, then floor by the shift.
  assign delta = ERR_W'((prod + PROD_W'(32768)) >>> 16);

  assign cand_pan  = $signed({{(CAND_W-ANG_W){1'b0}}, pan_r}) + CAND_W'(delta);
  assign cand_tilt = $signed({{(CAND_W-ANG_W){1'b0}}, tilt_r}) - CAND_W'(delta);

  assign cmp_val = prod[CMP_SHIFT+CMP_W-1:CMP_SHIFT] + CMP_OFFSET;

  always_comb begin
    state_nxt = state_r;
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    errx_nxt  = errx_r;
    erry_nxt  = erry_r;
    trk_nxt   = trk_r;
    pcmp_nxt  = pcmp_r;
    ov_nxt    = ov_r && !out_ch.ready;
    opan_nxt  = opan_r;
    otilt_nxt = otilt_r;
    opcmp_nxt = opcmp_r;
    otcmp_nxt = otcmp_r;
    otrk_nxt  = otrk_r;
    mul_req.a = '0;
    mul_req.b = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          errx_nxt = $signed({in_ch.point_x[POS_W-1], in_ch.point_x})
                   - $signed({2'b00, cfg.target_x});
          erry_nxt = $signed({in_ch.point_y[POS_W-1], in_ch.point_y})
                   - $signed({2'b00, cfg.target_y});
          trk_nxt  = (in_ch.point_x != NO_POINT) && (in_ch.point_y != NO_POINT);
          state_nxt = S_EX;
        end
      end
      S_EX: begin
        mul_req.a = errx_r;
        mul_req.b = MB_W'(cfg.gain);
        state_nxt = S_EY;
      end
      S_EY: begin
        mul_req.a = erry_r;
        mul_req.b = MB_W'(cfg.gain);
        if (trk_r && cand_pan > $signed({5'b00000, cfg.pan_low})
            && cand_pan < $signed({5'b00000, cfg.pan_high})) begin
          pan_nxt = cand_pan[ANG_W-1:0];
        end
        state_nxt = S_CP;
      end
      S_CP: begin
        mul_req.a = $signed({{(ERR_W-ANG_W){1'b0}}, pan_r});
        mul_req.b = CMP_MULT;
        if (trk_r && cand_tilt > $signed({5'b00000, cfg.tilt_low})
            && cand_tilt < $signed({5'b00000, cfg.tilt_high})) begin
          tilt_nxt = cand_tilt[ANG_W-1:0];
        end
        state_nxt = S_CT;
      end
      S_CT: begin
        mul_req.a = $signed({{(ERR_W-ANG_W){1'b0}}, tilt_r});
        mul_req.b = CMP_MULT;
        pcmp_nxt  = cmp_val;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The tilt product stays in the multiplier register until the
        // output register is free.
        if (out_free) begin
          ov_nxt    = 1'b1;
          opan_nxt  = pan_r;
          otilt_nxt = tilt_r;
          opcmp_nxt = pcmp_r;
          otcmp_nxt = cmp_val;
          otrk_nxt  = trk_r;
          state_nxt = S_IDLE;
        end else begin
          mul_req.a = $signed({{(ERR_W-ANG_W){1'b0}}, tilt_r});
          mul_req.b = CMP_MULT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pan_r   <= RST_PAN;
      tilt_r  <= RST_TILT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pan_r   <= pan_nxt;
      tilt_r  <= tilt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    errx_r  <= errx_nxt;
    erry_r  <= erry_nxt;
    trk_r   <= trk_nxt;
    pcmp_r  <= pcmp_nxt;
    opan_r  <= opan_nxt;
    otilt_r <= otilt_nxt;
    opcmp_r <= opcmp_nxt;
    otcmp_r <= otcmp_nxt;
    otrk_r  <= otrk_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.pan_angle    = opan_r;
  assign out_ch.tilt_angle   = otilt_r;
  assign out_ch.pan_compare  = opcmp_r;
  assign out_ch.tilt_compare = otcmp_r;
  assign out_ch.tracked      = otrk_r;

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EX)
    else $error("accepted item did not start the sequence");

  a_pan_hold : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_EY |=> $stable(pan_r))
    else $error("pan angle changed outside its update step");

  a_tilt_untracked : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP && !trk_r) |=> $stable(tilt_r))
    else $error("tilt angle moved on an untracked item");

  a_done_loads : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (ov_r && state_r == S_IDLE))
    else $error("finished item was not loaded into the output register");
`endif

endmodule

// ===== rtl/core/pan_tilt_proportional_servo.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_proportional_servo: proportional pan/tilt tracker
// Turns one detected object position per item into new servo angles and
// PWM compare values.
// ----------------------------------------------------------------------------
// Each item runs through the sequencer from acceptance to a loaded result:
// the input is accepted in the idle state, four steps follow on the one
// shared multiplier (pan error times gain, tilt error times gain, pan and
// tilt compare scaling), and a last step loads the output register. The next
// item is accepted in the cycle after that load, so no new item is taken
// while one is in flight; a stalled output register holds the sequencer in
// its last step until the previous result is taken. Configuration writes
// take effect at once and are meant to be issued while no item is in flight.
module pan_tilt_proportional_servo (
  input  logic                          clk,
  input  logic                          rst_n,
  pts_in_if.sink                        in_ch,
  pts_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pts_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import pts_pkg::*;

  cfg_t                     cfg;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  pts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pts_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  pts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mul_req (mul_req),
    .prod    (prod)
  );

endmodule
